FILE: design/rssi_resample_period_estimator_core_assert.svh
// Assertion macros for the period estimator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RSSI_RESAMPLE_PERIOD_ESTIMATOR_CORE_ASSERT_SVH
`define RSSI_RESAMPLE_PERIOD_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define RRPE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rrpe_pkg.sv
// ----------------------------------------------------------------------------
// rrpe_pkg
// Types, constants and codes of the RSSI resampler and period estimator.
// ----------------------------------------------------------------------------
package rrpe_pkg;

  localparam int TS_W     = 48;
  localparam int RSSI_W   = 8;
  localparam int LAG_W    = 13;
  localparam int LAGX_W   = 14;
  localparam int PERIOD_W = 23;
  localparam int SUM_W    = 21;
  localparam int WIN_W    = 12;
  localparam int IDX_W    = 13;

  localparam int RING_DEPTH_DEF = 8192;

  localparam logic [9:0]  SAMPLE_INTERVAL_RST = 10'd100;
  localparam logic [19:0] GAP_LIMIT_RST       = 20'd100000;
  localparam logic [11:0] WINDOW_LEN_RST      = 12'd1000;
  localparam logic [6:0]  WINDOW_STEP_RST     = 7'd5;
  localparam logic [6:0]  LAG_STEP_RST        = 7'd5;
  localparam logic [12:0] MIN_LAG_RST         = 13'd100;
  localparam logic [12:0] MAX_LAG_RST         = 13'd5000;
  localparam logic [12:0] INITIAL_MAX_LAG_RST = 13'd3000;

  localparam logic [LAGX_W-1:0]        LAG_SPAN   = 14'd200;
  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -8'sd128;

  typedef enum logic [2:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_GAP_LIMIT       = 3'd1,
    REG_WINDOW_LEN      = 3'd2,
    REG_WINDOW_STEP     = 3'd3,
    REG_LAG_STEP        = 3'd4,
    REG_MIN_LAG         = 3'd5,
    REG_MAX_LAG         = 3'd6,
    REG_INITIAL_MAX_LAG = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [9:0]  sample_interval_us;
    logic [19:0] gap_limit_us;
    logic [11:0] window_len;
    logic [6:0]  window_step;
    logic [6:0]  lag_step;
    logic [12:0] min_lag;
    logic [12:0] max_lag;
    logic [12:0] initial_max_lag;
  } cfg_t;

  typedef struct packed {
    logic                enough_data;
    logic [LAG_W-1:0]    best_lag;
    logic [PERIOD_W-1:0] period_us;
    logic                peak_found;
    logic [TS_W-1:0]     peak_time_us;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_FILL,
    ST_TICK,
    ST_LAG_MOD,
    ST_LAG_START,
    ST_SUM,
    ST_LAG_CMP,
    ST_PEAK_SETUP,
    ST_PEAK,
    ST_PEAK_TIME,
    ST_PEAK_WAIT,
    ST_DONE
  } eng_state_e;

endpackage

FILE: design/rrpe_chan_if.sv
// ----------------------------------------------------------------------------
// rrpe_chan_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rrpe_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  logic [47:0]         timestamp_us;
  logic signed [7:0]   rssi;

  modport source (output valid, action, timestamp_us, rssi, input ready);
  modport sink   (input valid, action, timestamp_us, rssi, output ready);
endinterface

interface rrpe_out_if;
  logic        valid;
  logic        ready;
  logic        enough_data;
  logic [12:0] best_lag;
  logic [22:0] period_us;
  logic        peak_found;
  logic [47:0] peak_time_us;

  modport source (output valid, enough_data, best_lag, period_us, peak_found, peak_time_us,
                  input ready);
  modport sink   (input valid, enough_data, best_lag, period_us, peak_found, peak_time_us,
                  output ready);
endinterface

FILE: design/rrpe_ring.sv
// ----------------------------------------------------------------------------
// rrpe_ring
// Ring storage: RSSI memory with two read ports, time memory with one.
// ----------------------------------------------------------------------------
module rrpe_ring #(
  parameter int RING_DEPTH = 8192,
  parameter int AW         = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wrssi,
  input  logic [47:0]   wtime,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  input  logic [AW-1:0] rt_addr,
  output logic [7:0]    ra_data,
  output logic [7:0]    rb_data,
  output logic [47:0]   rt_data
);

  logic [7:0]  rssi_mem [RING_DEPTH];
  logic [47:0] time_mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      rssi_mem[waddr] <= wrssi;
      time_mem[waddr] <= wtime;
    end
    ra_data <= rssi_mem[ra_addr];
    rb_data <= rssi_mem[rb_addr];
    rt_data <= time_mem[rt_addr];
  end

endmodule

FILE: design/rrpe_ctrl.sv
// ----------------------------------------------------------------------------
// rrpe_ctrl
// Sequencer: grid fill into the ring, lag search and peak search.
// ----------------------------------------------------------------------------
`include "rssi_resample_period_estimator_core_assert.svh"

module rrpe_ctrl #(
  parameter int RING_DEPTH = 8192,
  parameter int AW         = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrpe_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [47:0]           in_timestamp_us,
  input  logic [7:0]            in_rssi,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rrpe_pkg::res_t        res,
  output logic                  ring_we,
  output logic [AW-1:0]         ring_waddr,
  output logic [7:0]            ring_wrssi,
  output logic [47:0]           ring_wtime,
  output logic [AW-1:0]         ring_ra_addr,
  output logic [AW-1:0]         ring_rb_addr,
  output logic [AW-1:0]         ring_rt_addr,
  input  logic [7:0]            ring_ra_data,
  input  logic [7:0]            ring_rb_data,
  input  logic [47:0]           ring_rt_data
);

  import rrpe_pkg::*;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p, input logic [31:0] s);
    logic [31:0] pw;
    pw = 32'(p);
    if (pw >= s) return AW'(pw - s);
    return AW'(pw + 32'(RING_DEPTH) - s);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (32'(p) == 32'(RING_DEPTH - 1)) return '0;
    return AW'(32'(p) + 32'd1);
  endfunction

  eng_state_e st_r, st_nxt;

  // ring control and model state
  logic [AW-1:0]     wp_r, wp_nxt, op_r, op_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              have_r, have_nxt;
  logic [TS_W-1:0]   last_r, last_nxt;
  logic [LAG_W-1:0]  prev_lag_r, prev_lag_nxt;
  logic [TS_W-1:0]   peak_time_r, peak_time_nxt;

  // working registers
  logic [TS_W-1:0]     ts_r, ts_nxt;
  logic [7:0]          rssi_r, rssi_nxt;
  logic [TS_W:0]       target_r, target_nxt;
  logic [AW-1:0]       head_r, head_nxt, bbase_r, bbase_nxt;
  logic [AW-1:0]       a_ptr_r, a_ptr_nxt, b_ptr_r, b_ptr_nxt;
  logic [LAGX_W-1:0]   lag_r, lag_nxt, lagmod_r, lagmod_nxt, end_r, end_nxt;
  logic [LAGX_W-1:0]   best_r, best_nxt, k_r, k_nxt;
  logic                any_r, any_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt, best_sum_r, best_sum_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic                iss_r, iss_nxt, av_r, av_nxt, bv_r, bv_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt, pk_idx_r, pk_idx_nxt;
  logic                pk_valid_r, pk_valid_nxt, found_r, found_nxt;
  logic signed [7:0]   maxv_r, maxv_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  res_t                res_r, res_nxt;

  logic [9:0]        step_eff;
  logic [6:0]        wstep_eff, lstep_eff;
  logic [TS_W:0]     gap_diff;
  logic [AW-1:0]     count;
  logic [LAGX_W-1:0] start_lag, end_lag, prev_x;
  logic signed [7:0] a_val, b_val;
  logic signed [8:0] ab_diff;
  logic [7:0]        ab_abs;
  logic [AW-1:0]     wp_inc;
  logic [TS_W-1:0]   peak_t;

  assign step_eff  = (cfg.sample_interval_us == '0) ? 10'd1 : cfg.sample_interval_us;
  assign wstep_eff = (cfg.window_step == '0) ? 7'd1 : cfg.window_step;
  assign lstep_eff = (cfg.lag_step == '0) ? 7'd1 : cfg.lag_step;

  assign gap_diff = {1'b0, ts_r} - {1'b0, last_r};
  assign count    = (wp_r >= op_r) ? AW'(wp_r - op_r)
                                   : AW'(32'(wp_r) + 32'(RING_DEPTH) - 32'(op_r));
  assign prev_x   = {1'b0, prev_lag_r};

  always_comb begin
    if (prev_lag_r == '0) begin
      start_lag = {1'b0, cfg.min_lag};
      end_lag   = {1'b0, cfg.initial_max_lag};
    end else begin
      start_lag = (prev_x >= LAG_SPAN + {1'b0, cfg.min_lag}) ? prev_x - LAG_SPAN
                                                              : {1'b0, cfg.min_lag};
      end_lag   = (prev_x + LAG_SPAN > {1'b0, cfg.max_lag}) ? {1'b0, cfg.max_lag}
                                                            : prev_x + LAG_SPAN;
    end
  end

  // unwritten entries read as zero
  assign a_val   = av_r ? $signed(ring_ra_data) : 8'sd0;
  assign b_val   = bv_r ? $signed(ring_rb_data) : 8'sd0;
  assign ab_diff = 9'(a_val) - 9'(b_val);
  assign ab_abs  = ab_diff[8] ? 8'(-ab_diff) : ab_diff[7:0];
  assign wp_inc  = ptr_inc(wp_r);
  assign peak_t  = pk_valid_r ? ring_rt_data : '0;

  always_comb begin
    st_nxt        = st_r;
    wp_nxt        = wp_r;
    op_nxt        = op_r;
    wrapped_nxt   = wrapped_r;
    have_nxt      = have_r;
    last_nxt      = last_r;
    prev_lag_nxt  = prev_lag_r;
    peak_time_nxt = peak_time_r;
    ts_nxt        = ts_r;
    rssi_nxt      = rssi_r;
    target_nxt    = target_r;
    head_nxt      = head_r;
    bbase_nxt     = bbase_r;
    a_ptr_nxt     = a_ptr_r;
    b_ptr_nxt     = b_ptr_r;
    lag_nxt       = lag_r;
    lagmod_nxt    = lagmod_r;
    end_nxt       = end_r;
    best_nxt      = best_r;
    k_nxt         = k_r;
    any_nxt       = any_r;
    sum_nxt       = sum_r;
    best_sum_nxt  = best_sum_r;
    i_nxt         = i_r;
    iss_nxt       = 1'b0;
    av_nxt        = av_r;
    bv_nxt        = bv_r;
    pidx_nxt      = pidx_r;
    pk_idx_nxt    = pk_idx_r;
    pk_valid_nxt  = pk_valid_r;
    found_nxt     = found_r;
    maxv_nxt      = maxv_r;
    period_nxt    = period_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ring_we       = 1'b0;
    ring_wrssi    = rssi_r;
    ring_wtime    = ts_r;
    ring_ra_addr  = a_ptr_r;
    ring_rb_addr  = b_ptr_r;
    ring_rt_addr  = pk_idx_r;

    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ts_nxt   = in_timestamp_us;
          rssi_nxt = in_rssi;
          st_nxt   = in_action ? ST_TICK : ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (!have_r || (ts_r > last_r && gap_diff > {29'd0, cfg.gap_limit_us})) begin
          // first sample or long gap: store as it came
          ring_we  = 1'b1;
          last_nxt = ts_r;
          have_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end else begin
          target_nxt = {1'b0, last_r} + {39'd0, step_eff};
          st_nxt     = ST_FILL;
        end
      end
      ST_FILL: begin
        if (target_r <= {1'b0, ts_r}) begin
          ring_we    = 1'b1;
          ring_wtime = target_r[TS_W-1:0];
          last_nxt   = target_r[TS_W-1:0];
          target_nxt = target_r + {39'd0, step_eff};
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        head_nxt = ptr_dec(wp_r, 32'd1);
        if (32'(count) < {19'd0, cfg.window_len, 1'b0}) begin
          res_nxt = '{enough_data: 1'b0, best_lag: '0, period_us: '0, peak_found: 1'b0,
                      peak_time_us: peak_time_r};
          st_nxt  = ST_DONE;
        end else begin
          lag_nxt    = start_lag;
          lagmod_nxt = start_lag;
          end_nxt    = end_lag;
          best_nxt   = '0;
          any_nxt    = 1'b0;
          st_nxt     = ST_LAG_MOD;
        end
      end
      ST_LAG_MOD: begin
        // reduce the first lag modulo the ring depth
        if (32'(lagmod_r) >= 32'(RING_DEPTH)) begin
          lagmod_nxt = LAGX_W'(32'(lagmod_r) - 32'(RING_DEPTH));
        end else begin
          bbase_nxt = ptr_dec(head_r, 32'(lagmod_r));
          st_nxt    = ST_LAG_START;
        end
      end
      ST_LAG_START: begin
        if (lag_r > end_r) begin
          st_nxt = ST_PEAK_SETUP;
        end else begin
          a_ptr_nxt = head_r;
          b_ptr_nxt = bbase_r;
          i_nxt     = '0;
          sum_nxt   = '0;
          st_nxt    = ST_SUM;
        end
      end
      ST_SUM: begin
        if (i_r < {1'b0, cfg.window_len}) begin
          iss_nxt   = 1'b1;
          av_nxt    = wrapped_r || (a_ptr_r < wp_r);
          bv_nxt    = wrapped_r || (b_ptr_r < wp_r);
          a_ptr_nxt = ptr_dec(a_ptr_r, 32'(wstep_eff));
          b_ptr_nxt = ptr_dec(b_ptr_r, 32'(wstep_eff));
          i_nxt     = i_r + IDX_W'(wstep_eff);
        end else if (!iss_r) begin
          st_nxt = ST_LAG_CMP;
        end
        if (iss_r) begin
          sum_nxt = sum_r + SUM_W'(ab_abs);
        end
      end
      ST_LAG_CMP: begin
        if (!any_r || sum_r < best_sum_r) begin
          any_nxt      = 1'b1;
          best_sum_nxt = sum_r;
          best_nxt     = lag_r;
        end
        lag_nxt   = lag_r + LAGX_W'(lstep_eff);
        bbase_nxt = ptr_dec(bbase_r, 32'(lstep_eff));
        st_nxt    = ST_LAG_START;
      end
      ST_PEAK_SETUP: begin
        if (best_r == '0) begin
          res_nxt = '{enough_data: 1'b1, best_lag: '0, period_us: '0, peak_found: 1'b0,
                      peak_time_us: peak_time_r};
          st_nxt  = ST_DONE;
        end else begin
          prev_lag_nxt = best_r[LAG_W-1:0];
          period_nxt   = PERIOD_W'(best_r * step_eff);
          a_ptr_nxt    = head_r;
          k_nxt        = '0;
          maxv_nxt     = RSSI_FLOOR;
          found_nxt    = 1'b0;
          pk_valid_nxt = 1'b0;
          st_nxt       = ST_PEAK;
        end
      end
      ST_PEAK: begin
        if (k_r < best_r) begin
          iss_nxt   = 1'b1;
          av_nxt    = wrapped_r || (a_ptr_r < wp_r);
          pidx_nxt  = a_ptr_r;
          a_ptr_nxt = ptr_dec(a_ptr_r, 32'd1);
          k_nxt     = k_r + 1'b1;
        end else if (!iss_r) begin
          st_nxt = ST_PEAK_TIME;
        end
        // keep the first strict maximum, newest first
        if (iss_r && (a_val > maxv_r)) begin
          maxv_nxt     = a_val;
          pk_idx_nxt   = pidx_r;
          pk_valid_nxt = av_r;
          found_nxt    = 1'b1;
        end
      end
      ST_PEAK_TIME: begin
        if (found_r) begin
          st_nxt = ST_PEAK_WAIT;
        end else begin
          res_nxt = '{enough_data: 1'b1, best_lag: best_r[LAG_W-1:0], period_us: period_r,
                      peak_found: 1'b0, peak_time_us: peak_time_r};
          st_nxt  = ST_DONE;
        end
      end
      ST_PEAK_WAIT: begin
        peak_time_nxt = peak_t;
        res_nxt = '{enough_data: 1'b1, best_lag: best_r[LAG_W-1:0], period_us: period_r,
                    peak_found: 1'b1, peak_time_us: peak_t};
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase

    // advance the ring pointers on every write; drop the oldest when full
    if (ring_we) begin
      wp_nxt = wp_inc;
      if (wp_inc == op_r) op_nxt = ptr_inc(op_r);
      if (wp_inc == '0) wrapped_nxt = 1'b1;
    end
  end

  assign ring_waddr = wp_r;
  assign res        = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      op_r        <= '0;
      wrapped_r   <= 1'b0;
      have_r      <= 1'b0;
      last_r      <= '0;
      prev_lag_r  <= '0;
      peak_time_r <= '0;
      iss_r       <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      op_r        <= op_nxt;
      wrapped_r   <= wrapped_nxt;
      have_r      <= have_nxt;
      last_r      <= last_nxt;
      prev_lag_r  <= prev_lag_nxt;
      peak_time_r <= peak_time_nxt;
      iss_r       <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r       <= ts_nxt;
    rssi_r     <= rssi_nxt;
    target_r   <= target_nxt;
    head_r     <= head_nxt;
    bbase_r    <= bbase_nxt;
    a_ptr_r    <= a_ptr_nxt;
    b_ptr_r    <= b_ptr_nxt;
    lag_r      <= lag_nxt;
    lagmod_r   <= lagmod_nxt;
    end_r      <= end_nxt;
    best_r     <= best_nxt;
    k_r        <= k_nxt;
    any_r      <= any_nxt;
    sum_r      <= sum_nxt;
    best_sum_r <= best_sum_nxt;
    i_r        <= i_nxt;
    av_r       <= av_nxt;
    bv_r       <= bv_nxt;
    pidx_r     <= pidx_nxt;
    pk_idx_r   <= pk_idx_nxt;
    pk_valid_r <= pk_valid_nxt;
    found_r    <= found_nxt;
    maxv_r     <= maxv_nxt;
    period_r   <= period_nxt;
    res_r      <= res_nxt;
  end

  `RRPE_ASSERT_IMPL(a_write_only_on_sample, ring_we, (st_r == ST_SAMPLE) || (st_r == ST_FILL), "ring written outside sample handling")
  `RRPE_ASSERT_NEXT(a_ring_never_full, ring_we, wp_r != op_r, "ring write left no free entry")
  `RRPE_ASSERT_IMPL(a_peak_needs_lag, st_r == ST_PEAK_TIME, best_r != '0, "peak search without a lag")

endmodule

FILE: design/rssi_resample_period_estimator_core.sv
// Sample item: stored as it came if first or after a long gap, else resampled by FILL.
// Tick item: per lag, a window sum over every window_step-th entry, one RSSI memory
//   read pair per cycle; then a peak search over the newest best_lag entries.
// One item is in work at a time; a finished result waits in the output register.
// Reset: synchronous; state and configuration registers return to defaults, the ring
//   reads as empty at once (entries never written read as zero), no clearing pass.
// ----------------------------------------------------------------------------
// rssi_resample_period_estimator_core
// Top level: configuration registers, output register, sequencer and ring.
// ----------------------------------------------------------------------------
module rssi_resample_period_estimator_core #(
  parameter int RING_DEPTH = rrpe_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  rrpe_in_if.sink     in_ch,
  rrpe_out_if.source  out_ch
);

  import rrpe_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  cfg_t  cfg_r;
  res_t  res, out_r;
  logic  res_valid, out_valid_r, out_free;

  logic          ring_we;
  logic [AW-1:0] ring_waddr, ring_ra_addr, ring_rb_addr, ring_rt_addr;
  logic [7:0]    ring_wrssi, ring_ra_data, ring_rb_data;
  logic [47:0]   ring_wtime, ring_rt_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sample_interval_us: SAMPLE_INTERVAL_RST, gap_limit_us: GAP_LIMIT_RST,
                 window_len: WINDOW_LEN_RST, window_step: WINDOW_STEP_RST,
                 lag_step: LAG_STEP_RST, min_lag: MIN_LAG_RST, max_lag: MAX_LAG_RST,
                 initial_max_lag: INITIAL_MAX_LAG_RST};
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SAMPLE_INTERVAL: cfg_r.sample_interval_us <= cfg_wdata[9:0];
        REG_GAP_LIMIT:       cfg_r.gap_limit_us       <= cfg_wdata;
        REG_WINDOW_LEN:      cfg_r.window_len         <= cfg_wdata[11:0];
        REG_WINDOW_STEP:     cfg_r.window_step        <= cfg_wdata[6:0];
        REG_LAG_STEP:        cfg_r.lag_step           <= cfg_wdata[6:0];
        REG_MIN_LAG:         cfg_r.min_lag            <= cfg_wdata[12:0];
        REG_MAX_LAG:         cfg_r.max_lag            <= cfg_wdata[12:0];
        REG_INITIAL_MAX_LAG: cfg_r.initial_max_lag    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // output register: take a new result once the held one is transferred
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) out_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.enough_data  = out_r.enough_data;
  assign out_ch.best_lag     = out_r.best_lag;
  assign out_ch.period_us    = out_r.period_us;
  assign out_ch.peak_found   = out_r.peak_found;
  assign out_ch.peak_time_us = out_r.peak_time_us;

  rrpe_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_timestamp_us (in_ch.timestamp_us),
    .in_rssi         (in_ch.rssi),
    .res_valid       (res_valid),
    .res_ready       (out_free),
    .res             (res),
    .ring_we         (ring_we),
    .ring_waddr      (ring_waddr),
    .ring_wrssi      (ring_wrssi),
    .ring_wtime      (ring_wtime),
    .ring_ra_addr    (ring_ra_addr),
    .ring_rb_addr    (ring_rb_addr),
    .ring_rt_addr    (ring_rt_addr),
    .ring_ra_data    (ring_ra_data),
    .ring_rb_data    (ring_rb_data),
    .ring_rt_data    (ring_rt_data)
  );

  rrpe_ring #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wrssi   (ring_wrssi),
    .wtime   (ring_wtime),
    .ra_addr (ring_ra_addr),
    .rb_addr (ring_rb_addr),
    .rt_addr (ring_rt_addr),
    .ra_data (ring_ra_data),
    .rb_data (ring_rb_data),
    .rt_data (ring_rt_data)
  );

endmodule
